/* rtl/sbs_pkg.sv */
// Package for the sorted table binary search block.
// Holds the fixed field widths, command codes and the status group of the step unit.
// No dependencies.
package sbs_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned COMMAND_W     = 1;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ENTRY_COUNT_W = 9;

  // Command codes carried on the request channel.
  localparam logic [COMMAND_W-1:0] CMD_LOAD   = 1'b0;
  localparam logic [COMMAND_W-1:0] CMD_SEARCH = 1'b1;

  // Status flags produced by the step unit for the sequencer.
  typedef struct packed {
    logic hit;   // probed entry equals the key
    logic done;  // search ends this cycle (hit, bounds crossed or empty table)
  } sbs_flags_t;

endpackage

/* rtl/sbs_if.sv */
// Channel interfaces of the sorted table binary search block.
// Request, response and configuration channels with valid/ready handshakes.
// Depends on sbs_pkg.
interface sbs_req_if import sbs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [COMMAND_W-1:0]     command;
  logic [INDEX_W-1:0]       load_index;
  logic signed [WORD_W-1:0] load_value;
  logic signed [WORD_W-1:0] search_key;

  modport source (output valid, command, load_index, load_value, search_key, input ready);
  modport sink   (input valid, command, load_index, load_value, search_key, output ready);
endinterface

interface sbs_rsp_if import sbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

interface sbs_cfg_if import sbs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

/* rtl/sbs_table.sv */
// Table memory of the binary search block: one write port, one read port
// with registered read data. Contents are undefined until written.
// Depends on sbs_pkg.
module sbs_table import sbs_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data valid the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sbs_step.sv */
// Shared compare and bound update unit of the binary search block.
// Compares one probed entry with the key, narrows the bounds and forms the next midpoint.
// Depends on sbs_pkg.
module sbs_step import sbs_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                       start,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic [$clog2(DEPTH+1)-1:0] lo,
  input  logic [$clog2(DEPTH+1)-1:0] hi,
  input  logic [$clog2(DEPTH)-1:0]   mid,
  input  logic signed [WIDTH-1:0]    probe,
  input  logic signed [WIDTH-1:0]    key,
  output logic [$clog2(DEPTH+1)-1:0] lo_next,
  output logic [$clog2(DEPTH+1)-1:0] hi_next,
  output logic [$clog2(DEPTH)-1:0]   mid_next,
  output sbs_flags_t                 flags
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          less;
  logic          hit;
  logic [CW:0]   mid_sum;

  // Bounds are kept as [lo, hi) with hi one past the last candidate.
  always_comb begin
    hit  = (probe == key);
    less = (probe < key);
    if (start) begin
      lo_next = '0;
      hi_next = count;
    end else if (less) begin
      lo_next = CW'(mid) + CW'(1);
      hi_next = hi;
    end else begin
      lo_next = lo;
      hi_next = CW'(mid);
    end
  end

  // Floor midpoint of the remaining candidates: (lo + hi - 1) / 2.
  assign mid_sum  = (CW+1)'(lo_next) + (CW+1)'(hi_next) - (CW+1)'(1);
  assign mid_next = IW'(mid_sum >> 1);

  // The search ends on a match or when no candidate is left.
  assign flags.hit  = hit && !start;
  assign flags.done = (hit && !start) || (lo_next >= hi_next);

endmodule

/* rtl/sorted_table_binary_search.sv */
// Top level of the sorted table binary search block.
// Instantiates the table memory and the step unit and holds the search sequencer.
// Depends on sbs_pkg, the channel interfaces, sbs_table and sbs_step.
//
// A load transfer writes one signed value into the table and gives no
// response; loads at an index at or beyond TABLE_DEPTH are dropped. A search
// transfer gives one response: found and the index of the matching entry, or
// found low and index zero. The search probes one table entry per cycle: the
// accepting cycle issues the first read, and each later cycle compares the
// registered read data with the key in the step unit and issues the next read.
// The request channel is not ready while the search runs; it is ready again
// in the cycle in which the response appears. The single table read port and
// step unit keep the block to one search at a time. entry_count is written
// through the configuration channel, which is always ready; values above
// TABLE_DEPTH act as TABLE_DEPTH.
// Table entries hold no reset value and must be loaded before they are searched.
module sorted_table_binary_search import sbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  sbs_req_if.sink    req,
  sbs_rsp_if.source  rsp,
  sbs_cfg_if.sink    cfg
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]                     state;
  logic [ENTRY_COUNT_W-1:0]       entry_count;
  logic                           rsp_valid;
  logic                           found;
  logic [INDEX_W-1:0]             match_index;

  logic signed [VALUE_WIDTH-1:0]  key;
  logic [CW-1:0]                  lo;
  logic [CW-1:0]                  hi;
  logic [IW-1:0]                  mid;
  logic                           res_found;
  logic [INDEX_W-1:0]             res_index;

  logic [CW-1:0]                  count_clamped;
  logic [CW-1:0]                  lo_next;
  logic [CW-1:0]                  hi_next;
  logic [IW-1:0]                  mid_next;
  sbs_flags_t                     flags;
  logic signed [VALUE_WIDTH-1:0]  probe;

  logic                           req_xfer;
  logic                           start;
  logic                           wr_en;
  logic                           rd_en;
  logic signed [63:0]             load_wide;
  logic signed [63:0]             key_wide;
  logic signed [VALUE_WIDTH-1:0]  load_narrow;
  logic signed [VALUE_WIDTH-1:0]  key_narrow;

  // Handshakes.
  assign req.ready   = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = rsp_valid;
  assign rsp.found   = found;
  assign rsp.match_index = match_index;

  assign req_xfer = req.valid && req.ready;
  assign start    = req_xfer && (req.command == CMD_SEARCH);
  assign wr_en    = req_xfer && (req.command == CMD_LOAD)
                    && (32'(req.load_index) < 32'(TABLE_DEPTH));

  // Values are sign extended and then cut to the table width.
  assign load_wide   = 64'(req.load_value);
  assign key_wide    = 64'(req.search_key);
  assign load_narrow = load_wide[VALUE_WIDTH-1:0];
  assign key_narrow  = key_wide[VALUE_WIDTH-1:0];

  // Entry count limited to the table depth.
  assign count_clamped = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                 : CW'(entry_count);

  // A read is issued at the start of a search over a non-empty table and after every probe that does not end it.
  assign rd_en = (start && !flags.done) || ((state == ST_PROBE) && !flags.done);

  sbs_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IW'(req.load_index)),
    .wr_data (load_narrow),
    .rd_en   (rd_en),
    .rd_addr (mid_next),
    .rd_data (probe)
  );

  sbs_step #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_step (
    .start    (state == ST_IDLE),
    .count    (count_clamped),
    .lo       (lo),
    .hi       (hi),
    .mid      (mid),
    .probe    (probe),
    .key      (key),
    .lo_next  (lo_next),
    .hi_next  (hi_next),
    .mid_next (mid_next),
    .flags    (flags)
  );

  // Sequencer, configuration register and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        entry_count <= cfg.entry_count;
      end
      // The response is posted from the wait state and cleared once taken.
      if ((state == ST_WAIT) && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= flags.done ? ST_WAIT : ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (flags.done) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!rsp_valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Search bounds, key and pending result.
  always_ff @(posedge clk) begin
    if (start) begin
      key       <= key_narrow;
      lo        <= lo_next;
      hi        <= hi_next;
      mid       <= mid_next;
      res_found <= 1'b0;
      res_index <= '0;
    end else if (state == ST_PROBE) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
      if (flags.done) begin
        res_found <= flags.hit;
        res_index <= flags.hit ? INDEX_W'(mid) : '0;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if ((state == ST_WAIT) && (!rsp_valid || rsp.ready)) begin
      found       <= res_found;
      match_index <= res_index;
    end
  end

endmodule

/* rtl/sbs_checker.sv */
// Port-level checker for the sorted table binary search block, bound to the top level.
// Watches the request and response channels over time.
// Depends on sbs_pkg and sorted_table_binary_search.
module sbs_checker import sbs_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic [COMMAND_W-1:0] req_command,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic                 rsp_found,
  input logic [INDEX_W-1:0]   rsp_match_index
);

  // A stalled response keeps its valid and payload.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found)
                                   && $stable(rsp_match_index)))
    else $error("response changed while stalled");

  // A miss always reports index zero.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_found) |-> (rsp_match_index == '0))
    else $error("miss reported with a nonzero index");

  // The request channel closes once a search is accepted.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_command == CMD_SEARCH)) |=> !req_ready)
    else $error("request accepted during a search");

  // A load transfer never creates a response.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_command == CMD_LOAD) && !rsp_valid) |=> !rsp_valid)
    else $error("response appeared after a load");

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_command     (req.command),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_found       (rsp.found),
  .rsp_match_index (rsp.match_index)
);
